// File: rtl/laplacian_stencil_3d_defines.svh
// Assertion macros shared by the seven-point Laplacian checker
`ifndef LAPLACIAN_STENCIL_3D_DEFINES_SVH
`define LAPLACIAN_STENCIL_3D_DEFINES_SVH

// check the consequent in the same cycle as the antecedent
`define LS3D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check the consequent in the cycle after the antecedent
`define LS3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ls3d_pkg.sv
// Types and constants of the seven-point Laplacian stencil block
package ls3d_pkg;

  localparam int MAX_X = 1022;
  localparam int MAX_Y = 62;
  localparam int MAX_Z = 62;

  localparam int X_W = 10;
  localparam int Y_W = 6;
  localparam int Z_W = 6;

  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_W     = 16;

  localparam int DIFF_W = SAMPLE_W + 2;
  localparam int PROD_W = DIFF_W + COEF_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  localparam int ROW_W      = Y_W - 1;
  localparam int BANK_AW    = 1 + ROW_W + Z_W;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  localparam logic [CFG_IDX_W-1:0] CFG_X_INTERIOR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_INTERIOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_INTERIOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Z     = 3'd5;

  localparam int INTERIOR_RST = 62;
  localparam int COEF_RST     = 65536;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [BANK_AW-1:0]         bank_addr_t;

endpackage

// File: rtl/laplacian_stencil_3d.sv
// Seven-point Laplacian over a streamed, ghost-padded 3D grid
//
// channel  dir  handshake            payload
// cfg      in   cfg_we               cfg_index, cfg_data
// in       in   in_valid, in_ready   in_sample, in_frame_first
// out      out  out_valid, out_ready out_laplacian, out_last_point
//
// One word per cycle sustained while the output is taken; each of the two
// row banks serves two reads and one write per cycle, which sets that figure.
// Each word passes the read, difference, product, sum and output registers.
// Reset clears positions and valid bits and loads register defaults;
// the sample banks are not cleared.
// A full output register that is not taken freezes the pipe and drops in_ready.
module laplacian_stencil_3d (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ls3d_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ls3d_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [ls3d_pkg::SAMPLE_W-1:0]   in_sample,
  input  logic                                   in_frame_first,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [ls3d_pkg::SAMPLE_W-1:0]   out_laplacian,
  output logic                                   out_last_point
);
  import ls3d_pkg::*;

  function automatic logic [X_W-1:0] clamp_x(input logic [X_W-1:0] v);
    if (v == '0) return X_W'(1);
    if (v > X_W'(MAX_X)) return X_W'(MAX_X);
    return v;
  endfunction

  function automatic logic [Y_W-1:0] clamp_y(input logic [Y_W-1:0] v);
    if (v == '0) return Y_W'(1);
    if (v > Y_W'(MAX_Y)) return Y_W'(MAX_Y);
    return v;
  endfunction

  function automatic logic [Z_W-1:0] clamp_z(input logic [Z_W-1:0] v);
    if (v == '0) return Z_W'(1);
    if (v > Z_W'(MAX_Z)) return Z_W'(MAX_Z);
    return v;
  endfunction

  logic [X_W-1:0]    nx_r;
  logic [Y_W-1:0]    ny_r;
  logic [Z_W-1:0]    nz_r;
  logic [COEF_W-1:0] coef_x_r, coef_y_r, coef_z_r;

  logic [X_W-1:0] x_r, x_nxt, x_cur, cp;
  logic [Y_W-1:0] y_r, y_nxt, y_cur, yp1, ym1;
  logic [Z_W-1:0] z_r, z_nxt, z_cur, zp1;
  logic           adv, accept, interior, last_pt, row_end;

  bank_addr_t addr_self, addr_cz, addr_ym, addr_yp, addr_nrow;
  bank_addr_t a0, b0, a1, b1;
  logic       we0, we1;

  sample_t bank0_mem_r [BANK_DEPTH];
  sample_t bank1_mem_r [BANK_DEPTH];
  sample_t rd0a_r, rd0b_r, rd1a_r, rd1b_r;

  logic    s1_vld_r, s1_res_r, s1_last_r, s1_bank_r, s1_row_end_r;
  sample_t s1_raw_r;
  sample_t win_a_r, win_b_r;
  sample_t cur_a, cur_b, oth_a, oth_b, zp_v;
  diff_t   c2, dx, dy, dz;

  logic    s2_vld_r, s2_last_r;
  diff_t   dx_r, dy_r, dz_r;
  logic    s3_vld_r, s3_last_r;
  prod_t   px_r, py_r, pz_r;
  logic    s4_vld_r, s4_last_r;
  sum_t    sum_r;
  sum_t    rounded, shifted, sat_hi, sat_lo;
  sample_t lap_nxt;

  logic    out_valid_r, out_last_r;
  sample_t out_lap_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r     <= X_W'(INTERIOR_RST);
      ny_r     <= Y_W'(INTERIOR_RST);
      nz_r     <= Z_W'(INTERIOR_RST);
      coef_x_r <= COEF_W'(COEF_RST);
      coef_y_r <= COEF_W'(COEF_RST);
      coef_z_r <= COEF_W'(COEF_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_INTERIOR: nx_r <= clamp_x(cfg_data[X_W-1:0]);
        CFG_Y_INTERIOR: ny_r <= clamp_y(cfg_data[Y_W-1:0]);
        CFG_Z_INTERIOR: nz_r <= clamp_z(cfg_data[Z_W-1:0]);
        CFG_COEF_X:     coef_x_r <= cfg_data[COEF_W-1:0];
        CFG_COEF_Y:     coef_y_r <= cfg_data[COEF_W-1:0];
        CFG_COEF_Z:     coef_z_r <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    x_cur    = in_frame_first ? '0 : x_r;
    y_cur    = in_frame_first ? '0 : y_r;
    z_cur    = in_frame_first ? '0 : z_r;
    cp       = x_cur - X_W'(1);
    yp1      = y_cur + Y_W'(1);
    ym1      = y_cur - Y_W'(1);
    zp1      = z_cur + Z_W'(1);
    interior = (x_cur >= X_W'(2)) && (x_cur <= nx_r + X_W'(1)) &&
               (y_cur >= Y_W'(1)) && (y_cur <= ny_r) &&
               (z_cur >= Z_W'(1)) && (z_cur <= nz_r);
    last_pt  = (cp == nx_r) && (y_cur == ny_r) && (z_cur == nz_r);
    row_end  = (z_cur >= nz_r + Z_W'(1));
    x_nxt    = x_cur;
    y_nxt    = y_cur;
    z_nxt    = zp1;
    if (row_end) begin
      z_nxt = '0;
      if (y_cur >= ny_r + Y_W'(1)) begin
        y_nxt = '0;
        x_nxt = (x_cur >= nx_r + X_W'(1)) ? '0 : x_cur + X_W'(1);
      end else begin
        y_nxt = yp1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else if (accept) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    addr_self = {x_cur[0], y_cur[Y_W-1:1], z_cur};
    addr_cz   = {cp[0], y_cur[Y_W-1:1], zp1};
    addr_ym   = {cp[0], ym1[Y_W-1:1], z_cur};
    addr_yp   = {cp[0], yp1[Y_W-1:1], z_cur};
    addr_nrow = {cp[0], yp1[Y_W-1:1], {Z_W{1'b0}}};
    if (y_cur[0]) begin
      a1  = addr_cz;
      b1  = addr_self;
      we1 = accept;
      a0  = row_end ? addr_nrow : addr_ym;
      b0  = addr_yp;
      we0 = 1'b0;
    end else begin
      a0  = addr_cz;
      b0  = addr_self;
      we0 = accept;
      a1  = row_end ? addr_nrow : addr_ym;
      b1  = addr_yp;
      we1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd0a_r <= bank0_mem_r[a0];
      rd0b_r <= bank0_mem_r[b0];
      if (we0) begin
        bank0_mem_r[b0] <= in_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd1a_r <= bank1_mem_r[a1];
      rd1b_r <= bank1_mem_r[b1];
      if (we1) begin
        bank1_mem_r[b1] <= in_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r     <= interior;
      s1_last_r    <= last_pt;
      s1_bank_r    <= y_cur[0];
      s1_row_end_r <= row_end;
      s1_raw_r     <= in_sample;
    end
  end

  always_comb begin
    cur_a = s1_bank_r ? rd1a_r : rd0a_r;
    cur_b = s1_bank_r ? rd1b_r : rd0b_r;
    oth_a = s1_bank_r ? rd0a_r : rd1a_r;
    oth_b = s1_bank_r ? rd0b_r : rd1b_r;
    zp_v  = s1_row_end_r ? oth_a : cur_a;
    c2    = {{(DIFF_W-SAMPLE_W-1){win_a_r[SAMPLE_W-1]}}, win_a_r, 1'b0};
    dx    = diff_t'(s1_raw_r) + diff_t'(cur_b) - c2;
    dy    = diff_t'(oth_b) + diff_t'(oth_a) - c2;
    dz    = diff_t'(zp_v) + diff_t'(win_b_r) - c2;
  end

  always_ff @(posedge clk) begin
    if (adv && s1_vld_r) begin
      win_a_r <= zp_v;
      win_b_r <= win_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r    <= s1_vld_r && s1_res_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= s4_vld_r;
    end
  end

  always_comb begin
    rounded = sum_r + sum_t'(2 ** (FRAC_W - 1));
    shifted = rounded >>> FRAC_W;
    sat_hi  = {{(SUM_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    sat_lo  = ~sat_hi;
    if (shifted > sat_hi) begin
      lap_nxt = shifted[SAMPLE_W-1:0] | sample_t'(sat_hi[SAMPLE_W-1:0]);
      lap_nxt = sat_hi[SAMPLE_W-1:0];
    end else if (shifted < sat_lo) begin
      lap_nxt = sat_lo[SAMPLE_W-1:0];
    end else begin
      lap_nxt = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r       <= dx;
      dy_r       <= dy;
      dz_r       <= dz;
      s2_last_r  <= s1_last_r;
      px_r       <= prod_t'(dx_r) * prod_t'($signed({1'b0, coef_x_r}));
      py_r       <= prod_t'(dy_r) * prod_t'($signed({1'b0, coef_y_r}));
      pz_r       <= prod_t'(dz_r) * prod_t'($signed({1'b0, coef_z_r}));
      s3_last_r  <= s2_last_r;
      sum_r      <= sum_t'(px_r) + sum_t'(py_r) + sum_t'(pz_r);
      s4_last_r  <= s3_last_r;
      out_lap_r  <= lap_nxt;
      out_last_r <= s4_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_laplacian  = out_lap_r;
  assign out_last_point = out_last_r;

endmodule

// File: rtl/ls3d_checker.sv
// Port-level checker for the seven-point Laplacian block and its bind
`include "laplacian_stencil_3d_defines.svh"

module ls3d_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [ls3d_pkg::SAMPLE_W-1:0] out_laplacian,
  input logic                                 out_last_point
);

  `LS3D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `LS3D_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_laplacian) && $stable(out_last_point), "result word changed while stalled")
  `LS3D_ASSERT_SAME(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled without output back-pressure")
  `LS3D_ASSERT_NEXT(a_last_gap, out_valid && out_ready && out_last_point, !out_valid, "result word right after the last point")

endmodule

bind laplacian_stencil_3d ls3d_checker u_ls3d_checker (.*);

// File: tb/laplacian_stencil_3d_check.sv
// Checker for the seven-point Laplacian stencil: predicts each result word and compares it
`timescale 1ns / 100ps
module laplacian_stencil_3d_check
  import ls3d_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sample_t               in_sample,
  input  logic                  in_frame_first,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sample_t               out_laplacian,
  input  logic                  out_last_point,
  output int                    pending,
  output int                    errors
);

  localparam int ROW_WORDS   = MAX_Z + 2;
  localparam int PLANE_WORDS = (MAX_Y + 2) * ROW_WORDS;
  localparam longint SAT_HI  = 64'sd2147483647;
  localparam longint SAT_LO  = -64'sd2147483648;

  typedef struct packed {
    sample_t laplacian;
    logic    last_point;
  } lap_word_t;

  sample_t   plane_words [2 * PLANE_WORDS];
  lap_word_t lap_due [$];
  int        at_x, at_y, at_z;
  int        span_x, span_y, span_z;
  longint    wt_x, wt_y, wt_z;

  initial begin
    for (int i = 0; i < 2 * PLANE_WORDS; i++) plane_words[i] = '0;
    pending = 0;
    errors  = 0;
  end

  function automatic int used_span(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint plane_read(input int plane, input int y, input int z);
    return longint'(plane_words[(plane % 2) * PLANE_WORDS + y * ROW_WORDS + z]);
  endfunction

  task automatic absorb_sample(input sample_t s, input logic ff);
    int        nx, ny, nz, cp;
    longint    c2, d_x, d_y, d_z, acc, q;
    lap_word_t w;
    nx = used_span(span_x, MAX_X);
    ny = used_span(span_y, MAX_Y);
    nz = used_span(span_z, MAX_Z);
    if (ff) begin
      at_x = 0;
      at_y = 0;
      at_z = 0;
    end
    if (at_x >= 2 && at_x <= nx + 1 && at_y >= 1 && at_y <= ny &&
        at_z >= 1 && at_z <= nz) begin
      cp  = at_x - 1;
      c2  = 2 * plane_read(cp, at_y, at_z);
      d_x = longint'(s) + plane_read(at_x, at_y, at_z) - c2;
      d_y = plane_read(cp, at_y + 1, at_z) + plane_read(cp, at_y - 1, at_z) - c2;
      d_z = plane_read(cp, at_y, at_z + 1) + plane_read(cp, at_y, at_z - 1) - c2;
      acc = d_x * wt_x + d_y * wt_y + d_z * wt_z;
      q   = (acc + 64'sd32768) >>> FRAC_W;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      w.laplacian  = sample_t'(q);
      w.last_point = (cp == nx && at_y == ny && at_z == nz);
      lap_due.push_back(w);
    end
    plane_words[(at_x % 2) * PLANE_WORDS + at_y * ROW_WORDS + at_z] = s;
    if (at_z >= nz + 1) begin
      at_z = 0;
      if (at_y >= ny + 1) begin
        at_y = 0;
        at_x = (at_x >= nx + 1) ? 0 : at_x + 1;
      end else begin
        at_y = at_y + 1;
      end
    end else begin
      at_z = at_z + 1;
    end
  endtask

  always @(posedge clk) begin : track
    lap_word_t head;
    if (!rst_n) begin
      at_x   = 0;
      at_y   = 0;
      at_z   = 0;
      span_x = INTERIOR_RST;
      span_y = INTERIOR_RST;
      span_z = INTERIOR_RST;
      wt_x   = COEF_RST;
      wt_y   = COEF_RST;
      wt_z   = COEF_RST;
    end else begin
      if (out_valid && out_ready) begin
        if (lap_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: expected none, got laplacian %h last_point %b",
                   $time, out_laplacian, out_last_point);
        end else begin
          head = lap_due.pop_front();
          if (out_laplacian !== head.laplacian) begin
            errors++;
            $display("%0t: laplacian mismatch: expected %h, got %h",
                     $time, head.laplacian, out_laplacian);
          end
          if (out_last_point !== head.last_point) begin
            errors++;
            $display("%0t: last_point mismatch: expected %b, got %b",
                     $time, head.last_point, out_last_point);
          end
        end
      end
      if (in_valid && in_ready) absorb_sample(in_sample, in_frame_first);
      if (cfg_we) begin
        case (cfg_index)
          CFG_X_INTERIOR: span_x = int'(cfg_data[X_W-1:0]);
          CFG_Y_INTERIOR: span_y = int'(cfg_data[Y_W-1:0]);
          CFG_Z_INTERIOR: span_z = int'(cfg_data[Z_W-1:0]);
          CFG_COEF_X:     wt_x = longint'(cfg_data[COEF_W-1:0]);
          CFG_COEF_Y:     wt_y = longint'(cfg_data[COEF_W-1:0]);
          CFG_COEF_Z:     wt_z = longint'(cfg_data[COEF_W-1:0]);
          default: ;
        endcase
      end
    end
    pending = lap_due.size();
  end

endmodule

// File: tb/laplacian_stencil_3d_test.sv
// Stimulus and verdict for the seven-point Laplacian stencil over streamed 3D grids
`timescale 1ns / 100ps
module laplacian_stencil_3d_test;
  import ls3d_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 500;
  localparam int DRAIN_CYCLES = 12;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  sample_t               in_sample;
  logic                  in_frame_first;
  logic                  out_valid;
  logic                  out_ready;
  sample_t               out_laplacian;
  logic                  out_last_point;
  int                    pending;
  int                    errors;

  int words_sent = 0;
  int raw_x = INTERIOR_RST;
  int raw_y = INTERIOR_RST;
  int raw_z = INTERIOR_RST;
  bit at_origin = 1'b1;
  bit calm_in = 1'b0;

  always #10 clk = ~clk;

  laplacian_stencil_3d dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_frame_first (in_frame_first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_laplacian  (out_laplacian),
    .out_last_point (out_last_point)
  );

  laplacian_stencil_3d_check lap_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_frame_first (in_frame_first),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_laplacian  (out_laplacian),
    .out_last_point (out_last_point),
    .pending        (pending),
    .errors         (errors)
  );

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int used_span(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int grid_words();
    return (used_span(raw_x, MAX_X) + 2) * (used_span(raw_y, MAX_Y) + 2) *
           (used_span(raw_z, MAX_Z) + 2);
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 24'h01_0000;
      3:       return 24'h00_8000;
      4:       return {6'd0, r[17:0]};
      default: return r[COEF_W-1:0];
    endcase
  endfunction

  function automatic sample_t make_sample(input int mode);
    int pick;
    pick = $urandom_range(0, 5);
    case (mode)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 524288)) - 262144);
      default: begin
        case (pick)
          0:       return sample_t'(32'h7FFF_FFFF);
          1:       return sample_t'(32'h8000_0000);
          2:       return '0;
          3:       return '1;
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_X_INTERIOR: raw_x = int'(val[X_W-1:0]);
      CFG_Y_INTERIOR: raw_y = int'(val[Y_W-1:0]);
      CFG_Z_INTERIOR: raw_z = int'(val[Z_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_coefs(input bit whole);
    if (whole || $urandom_range(0, 1)) write_reg(CFG_COEF_X, pick_coef());
    if (whole || $urandom_range(0, 1)) write_reg(CFG_COEF_Y, pick_coef());
    if (whole || $urandom_range(0, 1)) write_reg(CFG_COEF_Z, pick_coef());
  endtask

  task automatic push_word(input sample_t s, input logic ff);
    int gap;
    gap = pick_gap(calm_in);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= s;
    in_frame_first <= ff;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_words(input int count, input bit ff_first, input int mode);
    for (int i = 0; i < count; i++) push_word(make_sample(mode), ff_first && i == 0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : result_side
    int hold, stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      repeat (hold) @(negedge clk);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin : stimulus
    int ex, ey, ez, total, cut, mode, shape, base;
    bit first;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_sample      = '0;
    in_frame_first = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_X_INTERIOR, 1);
    write_reg(CFG_Y_INTERIOR, 1);
    write_reg(CFG_Z_INTERIOR, 1);
    write_reg(CFG_COEF_X, '1);
    write_reg(CFG_COEF_Y, '1);
    write_reg(CFG_COEF_Z, '1);
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    total = grid_words();
    for (int i = 0; i < total; i++)
      push_word((i == 13) ? sample_t'(32'h8000_0000) : sample_t'(32'h7FFF_FFFF), 1'b0);

    for (int e = 0; e < 4; e++) begin
      wait_idle();
      case (e)
        0:       begin ex = 0;    ey = 63; ez = 0;  end
        1:       begin ex = 1;    ey = 0;  ez = 63; end
        2:       begin ex = 1023; ey = 1;  ez = 1;  end
        default: begin ex = 1022; ey = 2;  ez = 2;  end
      endcase
      write_reg(CFG_X_INTERIOR, ex);
      write_reg(CFG_Y_INTERIOR, ey);
      write_reg(CFG_Z_INTERIOR, ez);
      write_coefs(1'b1);
      calm_in = e[0];
      total = grid_words();
      cut = (e < 2) ? total : 4 * total / (used_span(raw_x, MAX_X) + 2);
      send_words(cut, !at_origin || ($urandom_range(0, 1) == 1), $urandom_range(0, 2));
      at_origin = (cut == total);
    end

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      wait_idle();
      if (words_sent == base || $urandom_range(0, 1))
        write_reg(CFG_X_INTERIOR, $urandom_range(0, 4));
      if (words_sent == base || $urandom_range(0, 1))
        write_reg(CFG_Y_INTERIOR, $urandom_range(0, 3));
      if (words_sent == base || $urandom_range(0, 1))
        write_reg(CFG_Z_INTERIOR, $urandom_range(0, 5));
      write_coefs(1'b0);
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
      mode    = $urandom_range(0, 2);
      calm_in = ($urandom_range(0, 4) == 0);
      total   = grid_words();
      shape   = $urandom_range(0, 9);
      first   = !at_origin || ($urandom_range(0, 1) == 1);
      if (shape < 2) begin
        send_words($urandom_range(1, total - 1), first, mode);
        at_origin = 1'b0;
      end else if (shape == 2) begin
        send_words($urandom_range(1, total - 1), first, mode);
        wait_idle();
        write_reg(CFG_X_INTERIOR, $urandom_range(1, used_span(raw_x, MAX_X)));
        write_reg(CFG_Y_INTERIOR, $urandom_range(1, used_span(raw_y, MAX_Y)));
        write_reg(CFG_Z_INTERIOR, $urandom_range(1, used_span(raw_z, MAX_Z)));
        send_words($urandom_range(1, 2 * grid_words()), 1'b0, mode);
        at_origin = 1'b0;
      end else begin
        send_words(total, first, mode);
        at_origin = 1'b1;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/ls3d_pkg.sv
rtl/laplacian_stencil_3d.sv
rtl/ls3d_checker.sv
tb/laplacian_stencil_3d_check.sv
tb/laplacian_stencil_3d_test.sv
